// ===== design/exclusive_data_set_framer_macros.svh =====
// Assertion shorthands used by edsf_frame.sv.
// The user module must have clk and rst_n in scope.
`ifndef EXCLUSIVE_DATA_SET_FRAMER_MACROS_SVH
`define EXCLUSIVE_DATA_SET_FRAMER_MACROS_SVH

// Same-cycle implication.
`define EDSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EDSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/edsf_pkg.sv =====
`timescale 1ns / 1ps

package edsf_pkg;

    // Data bytes per message before it is closed.
    localparam int CHUNK_BYTES = 256;
    localparam int COUNT_W     = $clog2(CHUNK_BYTES + 1);
    localparam int ADDR_W      = 21;
    localparam int SEVEN_W     = 7;

    // Fixed message bytes.
    localparam logic [7:0] SOX_BYTE   = 8'hF0;
    localparam logic [7:0] MAKER_BYTE = 8'h41;
    localparam logic [7:0] MODEL_BYTE = 8'h14;
    localparam logic [7:0] DT1_BYTE   = 8'h12;
    localparam logic [7:0] EOX_BYTE   = 8'hF7;

    // Position within one message burst.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_SOX   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_MAKER = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DEV   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_MODEL = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CMD   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ADDR2 = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ADDR1 = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ADDR0 = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DATA  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SUM   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_EOX   = 4'd10;

    typedef struct packed {
        logic [6:0]        device_id;
        logic [ADDR_W-1:0] start_address;
        logic [7:0]        data_byte;
        logic              last_of_block;
    } edsf_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       message_end;
        logic       run_end;
    } edsf_result_t;

endpackage

// ===== design/edsf_out_stage.sv =====
`timescale 1ns / 1ps

module edsf_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  edsf_pkg::edsf_result_t load_data,
    output logic                  ready,
    output logic                  result_valid,
    input  logic                  result_stall,
    output edsf_pkg::edsf_result_t result
);
    import edsf_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    edsf_result_t data_reg;

    // Register is free when empty or being drained this cycle.
    assign ready = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== design/edsf_frame.sv =====
`timescale 1ns / 1ps
`include "exclusive_data_set_framer_macros.svh"

module edsf_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  edsf_pkg::edsf_item_t   item,
    output edsf_pkg::edsf_result_t step_result,
    output logic                   last_byte
);
    import edsf_pkg::*;

    logic                in_run_reg;
    logic                in_message_reg;
    logic [COUNT_W-1:0]  chunk_count_reg;
    logic [SEVEN_W-1:0]  running_sum_reg;
    logic [ADDR_W-1:0]   chunk_address_reg;
    logic [SEVEN_W-1:0]  held_device_reg;
    logic [PHASE_W-1:0]  phase_reg;

    logic [SEVEN_W-1:0]  eff_dev;
    logic [ADDR_W-1:0]   eff_addr;
    logic [SEVEN_W-1:0]  addr2;
    logic [SEVEN_W-1:0]  addr1;
    logic [SEVEN_W-1:0]  addr0;
    logic [SEVEN_W-1:0]  addr_sum;
    logic [SEVEN_W-1:0]  base_sum;
    logic [SEVEN_W-1:0]  new_sum;
    logic [SEVEN_W-1:0]  check_sum;
    logic [COUNT_W-1:0]  base_count;
    logic [COUNT_W-1:0]  new_count;
    logic [ADDR_W-1:0]   next_addr;
    logic                close;
    logic [PHASE_W-1:0]  end_phase;
    logic [7:0]          byte_sel;

    // Device and address come from the item on the first byte of a run.
    assign eff_dev  = in_run_reg ? held_device_reg   : item.device_id;
    assign eff_addr = in_run_reg ? chunk_address_reg : item.start_address;
    assign addr2    = eff_addr[ADDR_W-1:2*SEVEN_W];
    assign addr1    = eff_addr[2*SEVEN_W-1:SEVEN_W];
    assign addr0    = eff_addr[SEVEN_W-1:0];
    assign addr_sum = addr2 + addr1 + addr0;

    assign base_sum   = in_message_reg ? running_sum_reg : addr_sum;
    assign new_sum    = base_sum + item.data_byte[SEVEN_W-1:0];
    assign check_sum  = SEVEN_W'(0) - new_sum;
    assign base_count = in_message_reg ? chunk_count_reg : '0;
    assign new_count  = base_count + COUNT_W'(1);
    assign next_addr  = eff_addr + ADDR_W'(new_count);

    assign close     = item.last_of_block || (new_count == COUNT_W'(CHUNK_BYTES));
    assign end_phase = close ? PH_EOX : PH_DATA;
    assign last_byte = (phase_reg == end_phase);

    always_comb
    begin
        unique case (phase_reg)
            PH_SOX:   byte_sel = SOX_BYTE;
            PH_MAKER: byte_sel = MAKER_BYTE;
            PH_DEV:   byte_sel = {1'b0, eff_dev};
            PH_MODEL: byte_sel = MODEL_BYTE;
            PH_CMD:   byte_sel = DT1_BYTE;
            PH_ADDR2: byte_sel = {1'b0, addr2};
            PH_ADDR1: byte_sel = {1'b0, addr1};
            PH_ADDR0: byte_sel = {1'b0, addr0};
            PH_DATA:  byte_sel = {1'b0, item.data_byte[SEVEN_W-1:0]};
            PH_SUM:   byte_sel = {1'b0, check_sum};
            PH_EOX:   byte_sel = EOX_BYTE;
            default:  byte_sel = '0;
        endcase
    end

    assign step_result.out_byte    = byte_sel;
    assign step_result.message_end = (phase_reg == PH_EOX);
    assign step_result.run_end     = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg        <= 1'b0;
            in_message_reg    <= 1'b0;
            chunk_count_reg   <= '0;
            running_sum_reg   <= '0;
            chunk_address_reg <= '0;
            held_device_reg   <= '0;
            phase_reg         <= PH_SOX;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                in_run_reg      <= !item.last_of_block;
                held_device_reg <= eff_dev;
                if (close)
                begin
                    in_message_reg    <= 1'b0;
                    chunk_count_reg   <= '0;
                    running_sum_reg   <= '0;
                    chunk_address_reg <= next_addr;
                    phase_reg         <= PH_SOX;
                end
                else
                begin
                    in_message_reg    <= 1'b1;
                    chunk_count_reg   <= new_count;
                    running_sum_reg   <= new_sum;
                    chunk_address_reg <= eff_addr;
                    phase_reg         <= PH_DATA;
                end
            end
            else
            begin
                phase_reg <= phase_reg + PHASE_W'(1);
            end
        end
    end

    `EDSF_ASSERT_NOW(a_msg_in_run, in_message_reg, in_run_reg, "open message outside a run")
    `EDSF_ASSERT_NOW(a_count_range, in_message_reg,
        (chunk_count_reg != '0) && (chunk_count_reg < COUNT_W'(CHUNK_BYTES)),
        "open message count out of range")
    `EDSF_ASSERT_NEXT(a_run_closes, advance && last_byte && item.last_of_block,
        !in_run_reg && !in_message_reg && (phase_reg == PH_SOX),
        "run end did not close message")
    `EDSF_ASSERT_NOW(a_open_skips_hdr, in_message_reg,
        (phase_reg == PH_DATA) || (phase_reg == PH_SUM) || (phase_reg == PH_EOX),
        "header phase inside an open message")

endmodule

// ===== design/exclusive_data_set_framer.sv =====
`timescale 1ns / 1ps
// Exclusive data-set framer.
// item channel: one payload byte per request (item_valid / item_stall / item).
//   device_id and start_address are taken from the first request of a run only;
//   last_of_block closes the run.
// result channel: one framed stream byte per request (result_valid / result_stall /
//   result). message_end flags the closing F7, run_end the last byte caused by a
//   given input request.
// A request waits in the input register; its bytes leave through the output register.
// Throughput: one output byte per cycle while the output register is not stalled.
//   A request mid-message produces one byte, so requests flow back to back.
//   A request that opens a message also emits the eight header bytes first, and
//   one that closes it adds the checksum and F7, as set by the byte sequencer.
// Reset (rst_n low, async): no run, no open message, input and output registers
//   empty; the next request starts a new run.
// Result stall: the output register holds its byte; the sequencer and the input
//   register freeze, and item_stall rises once the input register is occupied.
module exclusive_data_set_framer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  edsf_pkg::edsf_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output edsf_pkg::edsf_result_t result
);
    import edsf_pkg::*;

    // Input register: holds the request being framed.
    logic         item_valid_reg;
    logic         item_valid_next;
    edsf_item_t   item_reg;

    logic         item_take;
    logic         out_ready;
    logic         push;
    logic         last_byte;
    edsf_result_t step_result;

    // A byte moves into the output register whenever it has room.
    assign push = item_valid_reg && out_ready;

    // Input frees up in the same cycle its final byte is pushed.
    assign item_stall = item_valid_reg && !(push && last_byte);
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (push && last_byte)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
    end

    // Run/message state and byte sequencer.
    edsf_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (push),
        .item        (item_reg),
        .step_result (step_result),
        .last_byte   (last_byte)
    );

    // Result register, decouples the sequencer from the receiver.
    edsf_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (push),
        .load_data    (step_result),
        .ready        (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Framer testbench.
// Every accepted input request is run through a cycle-free model of the framer
// that builds the byte burst it should cause (header if it opens a message,
// data byte, checksum and F7 if it closes one). The bursts are queued in order.
// A monitor pops one entry per accepted output byte and compares it field by field.
// Both channels idle at random: the sender inserts gaps and the sink raises
// result_stall. Stretches with neither are mixed in.
module tb_top;

    import edsf_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 20;    // quiet cycles after the last expected byte
    localparam int IDLE_LIMIT    = 4000;  // cycles with no request moving on either side
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 210;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    edsf_item_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    edsf_result_t result;

    exclusive_data_set_framer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Framer model state: a private copy, advanced once per accepted
    // input request.
    // ------------------------------------------------------------------
    logic                  run_active  = 1'b0;
    logic                  msg_open    = 1'b0;
    logic [COUNT_W-1:0]    byte_count  = '0;
    logic [SEVEN_W-1:0]    sum7        = '0;
    logic [ADDR_W-1:0]     chunk_addr  = '0;
    logic [SEVEN_W-1:0]    dev_held    = '0;

    // Stream bytes still owed by the framer, oldest first.
    edsf_result_t expected_bytes[$];

    // Idling knobs, flipped by the tests.
    bit src_gaps_on    = 1'b0;
    bit sink_stalls_on = 1'b0;

    // Run statistics.
    int items_sent     = 0;
    int runs_sent      = 0;
    int bytes_seen     = 0;
    int messages_seen  = 0;
    int mismatch_count = 0;
    int unexpected     = 0;

    int stall_left  = 0;
    int idle_cycles = 0;

    // Mostly short idles, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic edsf_result_t frame_byte(input logic [7:0] b, input logic is_eox);
        edsf_result_t r;
        r.out_byte    = b;
        r.message_end = is_eox;
        r.run_end     = 1'b0;
        return r;
    endfunction

    // Expected burst for one accepted request; updates the model state.
    task automatic predict_frame_bytes(input edsf_item_t it);
        edsf_result_t       burst[$];
        edsf_result_t       tail;
        logic [SEVEN_W-1:0] a2;
        logic [SEVEN_W-1:0] a1;
        logic [SEVEN_W-1:0] a0;
        logic [SEVEN_W-1:0] d7;
        logic [SEVEN_W-1:0] check;

        // first request of a run latches device and address
        if (!run_active)
        begin
            dev_held   = it.device_id;
            chunk_addr = it.start_address;
            run_active = 1'b1;
            msg_open   = 1'b0;
            byte_count = '0;
            sum7       = '0;
        end

        // open a message: eight header bytes, address high group first
        if (!msg_open)
        begin
            a2 = chunk_addr[20:14];
            a1 = chunk_addr[13:7];
            a0 = chunk_addr[6:0];
            burst.push_back(frame_byte(SOX_BYTE, 1'b0));
            burst.push_back(frame_byte(MAKER_BYTE, 1'b0));
            burst.push_back(frame_byte({1'b0, dev_held}, 1'b0));
            burst.push_back(frame_byte(MODEL_BYTE, 1'b0));
            burst.push_back(frame_byte(DT1_BYTE, 1'b0));
            burst.push_back(frame_byte({1'b0, a2}, 1'b0));
            burst.push_back(frame_byte({1'b0, a1}, 1'b0));
            burst.push_back(frame_byte({1'b0, a0}, 1'b0));
            sum7       = a2 + a1 + a0;
            byte_count = '0;
            msg_open   = 1'b1;
        end

        d7 = it.data_byte[6:0];
        burst.push_back(frame_byte({1'b0, d7}, 1'b0));
        sum7       = sum7 + d7;
        byte_count = byte_count + 1'b1;

        // close on last byte of the run or on a full chunk
        if (it.last_of_block || byte_count >= CHUNK_BYTES)
        begin
            check = 7'd0 - sum7;
            burst.push_back(frame_byte({1'b0, check}, 1'b0));
            burst.push_back(frame_byte(EOX_BYTE, 1'b1));
            chunk_addr = chunk_addr + ADDR_W'(byte_count);  // wraps at 21 bits
            byte_count = '0;
            sum7       = '0;
            msg_open   = 1'b0;
        end

        if (it.last_of_block)
            run_active = 1'b0;

        tail = burst.pop_back();
        tail.run_end = 1'b1;
        burst.push_back(tail);
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
    endtask

    // Offer one request and hold it until the framer takes it.
    task automatic send_item(input edsf_item_t it);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 1) == 1)
            gap = pick_idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        // taken at this edge
        predict_frame_bytes(it);
        items_sent++;
        if (it.last_of_block)
            runs_sent++;
    endtask

    // Request with every field random.
    function automatic edsf_item_t random_item(input logic is_last);
        edsf_item_t it;
        it.device_id     = 7'($urandom_range(0, 127));
        it.start_address = ADDR_W'($urandom);
        it.data_byte     = 8'($urandom_range(0, 255));
        it.last_of_block = is_last;
        return it;
    endfunction

    function automatic edsf_item_t make_item(input logic [6:0] dev, input logic [ADDR_W-1:0] addr,
                                             input logic [7:0] data, input logic is_last);
        edsf_item_t it;
        it.device_id     = dev;
        it.start_address = addr;
        it.data_byte     = data;
        it.last_of_block = is_last;
        return it;
    endfunction

    // Sender holds off until the framer has emitted everything it owes.
    task automatic wait_for_stream_drain();
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One run of n bytes with random content; later requests carry noise in
    // the device and address fields, which the framer must ignore.
    task automatic send_run(input int n);
        for (int i = 0; i < n; i++)
            send_item(random_item(i == n - 1));
    endtask

    // ------------------------------------------------------------------
    // Sink: result_stall in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (sink_stalls_on && $urandom_range(0, 3) == 0)
        begin
            stall_left   <= pick_idle_len() - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted output byte with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        edsf_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            bytes_seen++;
            if (result.message_end)
                messages_seen++;
            if (expected_bytes.size() == 0)
            begin
                unexpected++;
                if (mismatch_count + unexpected <= MAX_REPORTS)
                    $display("[%0t] unexpected byte %02h end=%b run_end=%b",
                             $realtime, result.out_byte, result.message_end, result.run_end);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte
                    || result.message_end !== want.message_end
                    || result.run_end !== want.run_end)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected <= MAX_REPORTS)
                        $display({"[%0t] byte %0d: exp %02h end=%b run_end=%b, ",
                                  "got %02h end=%b run_end=%b"},
                                 $realtime, bytes_seen, want.out_byte, want.message_end,
                                 want.run_end, result.out_byte, result.message_end,
                                 result.run_end);
                end
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single-byte runs at the field extremes; data bit 7 must be masked off.
    task automatic test_single_byte_runs();
        send_item(make_item(7'd0,   21'h000000, 8'h00, 1'b1));
        send_item(make_item(7'd127, 21'h1FFFFF, 8'hFF, 1'b1));
        send_item(make_item(7'd85,  21'h155555, 8'h80, 1'b1));
        send_item(make_item(7'd42,  21'h0AAAAA, 8'h7F, 1'b1));
        send_item(make_item(7'd1,   21'h003F80, 8'h01, 1'b1));
        wait_for_stream_drain();
    endtask

    // Device and address come from the first request only.
    task automatic test_run_start_latch();
        send_item(make_item(7'd16,  21'h012345, 8'h55, 1'b0));
        send_item(make_item(7'd127, 21'h1FFFFF, 8'hAA, 1'b0));
        send_item(make_item(7'd0,   21'h000000, 8'hFF, 1'b0));
        send_item(make_item(7'd99,  21'h0F0F0F, 8'h00, 1'b0));
        send_item(make_item(7'd3,   21'h1E1E1E, 8'hC3, 1'b1));
        // back-to-back run right after a close
        send_item(make_item(7'd127, 21'h1FFF00, 8'h3C, 1'b0));
        send_item(make_item(7'd0,   21'h000001, 8'h81, 1'b1));
        wait_for_stream_drain();
    endtask

    // Exactly one chunk: full-chunk close and last close on the same byte.
    task automatic test_full_chunk();
        send_item(make_item(7'd9, 21'h000100, 8'($urandom_range(0, 255)), 1'b0));
        send_run(CHUNK_BYTES - 1);
        wait_for_stream_drain();
    endtask

    // Run spans two chunks; the second chunk address wraps past 2^21.
    task automatic test_address_wrap();
        send_item(make_item(7'd77, 21'h1FFF80, 8'($urandom_range(0, 255)), 1'b0));
        send_run(299);
        wait_for_stream_drain();
    endtask

    // Mostly short runs with random content, idling switched per segment,
    // and an occasional full drain by the sender.
    task automatic test_random_runs();
        int start_count;
        int len;
        int run_idx;
        start_count = items_sent;
        run_idx     = 0;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (run_idx % 6 == 0)
            begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            send_run(len);
            if (run_idx % 11 == 10)
                wait_for_stream_drain();
            run_idx++;
        end
        wait_for_stream_drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part starts with no idling, then with both sides idling
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_single_byte_runs();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        test_single_byte_runs();
        test_run_start_latch();
        test_full_chunk();
        test_address_wrap();
        test_random_runs();

        // stop stalling so any stray byte shows up during the final settle
        sink_stalls_on = 1'b0;
        wait_for_stream_drain();

        $display("Sent %0d requests in %0d runs; checked %0d stream bytes in %0d messages.",
                 items_sent, runs_sent, bytes_seen, messages_seen);
        $display("Covered field extremes, run-start latching, full chunks and address wrap.");
        if (mismatch_count == 0 && unexpected == 0 && expected_bytes.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     mismatch_count, unexpected, expected_bytes.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/edsf_pkg.sv
design/edsf_out_stage.sv
design/edsf_frame.sv
design/exclusive_data_set_framer.sv
tb/tb_top.sv
